@@ hdl/apdb_pkg.sv @@
// Shared types, codes and constant tables for the angular point projector.
// No dependencies; the CORDIC unit and the top level refer to it by scoped names.
package apdb_pkg;

  localparam int VEC_FRAC = 16;
  localparam int TAB_FRAC = 24;
  localparam int TAB_LEN  = 24;
  localparam int ANG_W    = 9;
  localparam int MAG_W    = 8;
  localparam int RECIP_W  = 17;

  localparam logic [3:0] EMPTY_BIN = 4'd9;
  localparam logic [3:0] FAR_BIN   = 4'd7;

  typedef logic [4:0] tab_idx_t;

  typedef enum logic [1:0] {
    MODE_PLOT  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Z,
    ST_SQ_Y,
    ST_COL,
    ST_COL_WAIT,
    ST_ROW,
    ST_ROW_WAIT,
    ST_SCALE,
    ST_RD,
    ST_UPDATE
  } state_t;

  // atan(2^-i) in degrees, 24 fractional bits
  localparam logic [29:0] ATAN_Q24 [TAB_LEN] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234683,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115
  };

  // squared-distance limits 3*(14k)^2 for bins 1..6
  localparam logic [14:0] BIN_LIMIT [6] = '{
    15'd588, 15'd2352, 15'd5292, 15'd9408, 15'd14700, 15'd21168
  };

  // table entry rounded half-up to frac fractional bits
  function automatic logic [31:0] atan_entry(tab_idx_t idx, int frac);
    logic [31:0] t;
    int          sh;
    t  = 32'(ATAN_Q24[idx]);
    sh = TAB_FRAC - frac;
    if (sh <= 0) begin
      return t;
    end
    return (t + (32'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

@@ hdl/apdb_cordic.sv @@
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, integer degrees out.
// Depends on apdb_pkg (angle table, angle width).
module apdb_cordic #(
  parameter int VW   = 31,
  parameter int FRAC = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [VW-1:0]             a_in,
  input  logic signed [VW-1:0]             b_in,
  output logic                             busy,
  output logic signed [apdb_pkg::ANG_W-1:0] deg
);

  localparam int AW = FRAC + 9;
  localparam int CW = $clog2(FRAC + 1);
  localparam logic signed [AW-1:0] NINETY = AW'(90) << FRAC;

  logic signed [VW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic signed [VW-1:0] da, db;
  logic signed [AW-1:0] acc_r, acc_nxt, te;
  logic [AW-1:0]        mag;
  logic [apdb_pkg::ANG_W-1:0] whole;
  logic [CW-1:0]        i_r, i_nxt;
  logic                 busy_r, busy_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    da       = b_r >>> i_r;
    db       = a_r >>> i_r;
    te       = AW'(apdb_pkg::atan_entry(apdb_pkg::tab_idx_t'(i_r), FRAC));
    if (start) begin
      if (a_in < 0 || (a_in == 0 && b_in != 0)) begin
        if (b_in >= 0) begin
          a_nxt   = b_in;
          b_nxt   = -a_in;
          acc_nxt = NINETY;
        end else begin
          a_nxt   = -b_in;
          b_nxt   = a_in;
          acc_nxt = -NINETY;
        end
      end else begin
        a_nxt   = a_in;
        b_nxt   = b_in;
        acc_nxt = '0;
      end
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r > 0) begin
        a_nxt   = a_r + da;
        b_nxt   = b_r - db;
        acc_nxt = acc_r + te;
      end else if (b_r < 0) begin
        a_nxt   = a_r - da;
        b_nxt   = b_r + db;
        acc_nxt = acc_r - te;
      end
      if (i_r == CW'(FRAC - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
  end

  // truncate toward zero
  always_comb begin
    mag   = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
    whole = apdb_pkg::ANG_W'(mag >> FRAC);
    deg   = acc_r[AW-1] ? -$signed(whole) : $signed(whole);
  end

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule

@@ hdl/apdb_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
// Standalone; used by the top level for the horizontal range.
module apdb_isqrt #(
  parameter int W = 58
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   n_in,
  output logic           busy,
  output logic [W/2-1:0] root
);

  logic [W-1:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt, trial;
  logic         busy_r, busy_nxt;

  always_comb begin
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    trial    = res_r + bit_r;
    if (start) begin
      n_nxt    = n_in;
      res_nxt  = '0;
      bit_nxt  = W'(1) << (W - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt   = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = res_r[W/2-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

endmodule

@@ hdl/angular_point_projector_depth_bins.sv @@
// Plot: squares the coordinates, runs the square-root unit beside the first of two passes through
// the one CORDIC unit, then scales, reads and updates; off-screen plot: stops after scaling;
// read: memory read, then report; bad read address or no-op: reported from idle; clear: a sweep.
// One word at a time, busy until done. Synchronous reset sweeps the screen memory to empty,
// one entry a cycle, busy held high. Results appear for one cycle on out_valid; the receiver
// cannot stall.
module angular_point_projector_depth_bins #(
  parameter int SCREEN_COLS     = 90,
  parameter int SCREEN_ROWS     = 45,
  parameter int H_COMPRESS      = 1,
  parameter int V_COMPRESS      = 2,
  parameter int COORD_BITS      = 12,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  input  logic [5:0]                   in_read_row,
  input  logic [6:0]                   in_read_col,
  output logic                         out_valid,
  output logic                         out_in_bounds,
  output logic [5:0]                   out_row,
  output logic [6:0]                   out_col,
  output logic [3:0]                   out_pixel_value,
  output logic                         out_changed
);

  localparam int CB     = COORD_BITS;
  localparam int VF     = apdb_pkg::VEC_FRAC;
  localparam int VW     = CB + VF + 3;          // vector width with CORDIC growth headroom
  localparam int SQ_W   = 2 * CB + 2 + 2 * VF;  // radicand width, even
  localparam int RT_W   = SQ_W / 2;
  localparam int H2W    = 2 * CB + 1;
  localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AGW    = apdb_pkg::ANG_W;
  localparam int MW     = apdb_pkg::MAG_W;
  localparam int PW     = apdb_pkg::MAG_W + apdb_pkg::RECIP_W;
  // reciprocals for truncating division of |angle| <= 180 by the compress factors
  localparam logic [apdb_pkg::RECIP_W-1:0] H_RECIP =
    apdb_pkg::RECIP_W'((65536 + H_COMPRESS - 1) / H_COMPRESS);
  localparam logic [apdb_pkg::RECIP_W-1:0] V_RECIP =
    apdb_pkg::RECIP_W'((65536 + V_COMPRESS - 1) / V_COMPRESS);

  apdb_pkg::state_t state_r, state_nxt;
  apdb_pkg::mode_t  mode_r, mode_nxt;

  logic signed [CB-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [H2W-1:0]        h2_r, h2_nxt, d2_r, d2_nxt;
  logic signed [AGW-1:0] col_deg_r, col_deg_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt, clr_cnt_r, clr_cnt_nxt;
  logic                  clr_item_r, clr_item_nxt;
  logic [3:0]            bin_r, bin_nxt;
  logic [MW-1:0]         qrow_r, qrow_nxt, qcol_r, qcol_nxt;

  // shared squarer
  logic signed [CB-1:0]   mul_op;
  logic signed [2*CB-1:0] prod;
  logic [2*CB-1:0]        sq;

  // shared angle unit, and the root unit
  logic                  cor_start, cor_busy, sq_start, sq_busy;
  logic signed [VW-1:0]  cor_a, cor_b, x_ext, y_ext, z_ext;
  logic signed [AGW-1:0] cor_deg;
  logic [SQ_W-1:0]       sq_n;
  logic [RT_W-1:0]       root;

  // scaling, bounds and depth bin
  logic          c_neg, r_neg, col_ok, row_ok, scale_ok, rd_ok, last_clr, lower;
  logic [AGW-1:0] c_abs, r_abs;
  logic [PW-1:0] c_prod, r_prod;
  logic [MW-1:0] c_q, r_q;
  logic [3:0]    bin_calc;

  // screen memory
  logic [3:0]        mem [DEPTH];
  logic [3:0]        rd_q, wd;
  logic              we;
  logic [ADDR_W-1:0] wa;

  // result word
  logic       emit, e_inb, e_chg;
  logic [5:0] e_row;
  logic [6:0] e_col;
  logic [3:0] e_pix;
  logic       out_valid_r, out_in_bounds_r, out_changed_r;
  logic [5:0] out_row_r;
  logic [6:0] out_col_r;
  logic [3:0] out_pixel_value_r;

  assign busy     = (state_r != apdb_pkg::ST_IDLE);
  assign last_clr = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign rd_ok    = (32'(in_read_row) < SCREEN_ROWS) && (32'(in_read_col) < SCREEN_COLS);

  // squarer operand follows the sequencer
  always_comb begin
    case (state_r)
      apdb_pkg::ST_SQ_X: mul_op = x_r;
      apdb_pkg::ST_SQ_Z: mul_op = z_r;
      default:           mul_op = y_r;
    endcase
    prod = mul_op * mul_op;
    sq   = prod;
  end

  // coordinates in 16-bit fraction, sign extended to the vector width
  assign x_ext = $signed({{(VW - CB - VF){x_r[CB-1]}}, x_r, {VF{1'b0}}});
  assign y_ext = $signed({{(VW - CB - VF){y_r[CB-1]}}, y_r, {VF{1'b0}}});
  assign z_ext = $signed({{(VW - CB - VF){z_r[CB-1]}}, z_r, {VF{1'b0}}});

  // first pass: column angle of (x,z); second pass: row angle of (hypot, y)
  assign cor_start = (state_r == apdb_pkg::ST_COL) || (state_r == apdb_pkg::ST_ROW);
  assign cor_a     = (state_r == apdb_pkg::ST_ROW) ? $signed(VW'(root)) : x_ext;
  assign cor_b     = (state_r == apdb_pkg::ST_ROW) ? y_ext : z_ext;
  assign sq_start  = (state_r == apdb_pkg::ST_COL);
  assign sq_n      = SQ_W'(h2_r) << (2 * VF);

  apdb_cordic #(
    .VW   (VW),
    .FRAC (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .a_in  (cor_a),
    .b_in  (cor_b),
    .busy  (cor_busy),
    .deg   (cor_deg)
  );

  apdb_isqrt #(
    .W (SQ_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n_in  (sq_n),
    .busy  (sq_busy),
    .root  (root)
  );

  // Divide each angle magnitude by its compress factor (reciprocal multiply),
  // then reject a negative angle; a negative angle that truncates to zero lands on 0.
  // The row angle is still held by the CORDIC unit in the scale state.
  always_comb begin
    c_neg    = col_deg_r[AGW-1];
    r_neg    = cor_deg[AGW-1];
    c_abs    = c_neg ? AGW'(-col_deg_r) : AGW'(col_deg_r);
    r_abs    = r_neg ? AGW'(-cor_deg) : AGW'(cor_deg);
    c_prod   = PW'(c_abs[MW-1:0]) * PW'(H_RECIP);
    r_prod   = PW'(r_abs[MW-1:0]) * PW'(V_RECIP);
    c_q      = c_prod[16 +: MW];
    r_q      = r_prod[16 +: MW];
    col_ok   = !(c_neg && c_q != '0) && (32'(c_q) < SCREEN_COLS);
    row_ok   = !(r_neg && r_q != '0) && (32'(r_q) < SCREEN_ROWS);
    scale_ok = col_ok && row_ok;
  end

  // nearest bin whose limit the squared distance stays under
  always_comb begin
    bin_calc = apdb_pkg::FAR_BIN;
    for (int k = 5; k >= 0; k--) begin
      if (d2_r < H2W'(apdb_pkg::BIN_LIMIT[k])) begin
        bin_calc = 4'(k + 1);
      end
    end
  end

  assign lower = (rd_q > bin_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      apdb_pkg::ST_CLEAR: begin
        if (last_clr) begin
          state_nxt = apdb_pkg::ST_IDLE;
        end
      end
      apdb_pkg::ST_IDLE: begin
        if (start) begin
          case (apdb_pkg::mode_t'(in_mode))
            apdb_pkg::MODE_PLOT:  state_nxt = apdb_pkg::ST_SQ_X;
            apdb_pkg::MODE_READ:  state_nxt = rd_ok ? apdb_pkg::ST_RD : apdb_pkg::ST_IDLE;
            apdb_pkg::MODE_CLEAR: state_nxt = apdb_pkg::ST_CLEAR;
            default:              state_nxt = apdb_pkg::ST_IDLE;
          endcase
        end
      end
      apdb_pkg::ST_SQ_X: state_nxt = apdb_pkg::ST_SQ_Z;
      apdb_pkg::ST_SQ_Z: state_nxt = apdb_pkg::ST_SQ_Y;
      apdb_pkg::ST_SQ_Y: state_nxt = apdb_pkg::ST_COL;
      apdb_pkg::ST_COL:  state_nxt = apdb_pkg::ST_COL_WAIT;
      apdb_pkg::ST_COL_WAIT: begin
        if (!cor_busy && !sq_busy) begin
          state_nxt = apdb_pkg::ST_ROW;
        end
      end
      apdb_pkg::ST_ROW: state_nxt = apdb_pkg::ST_ROW_WAIT;
      apdb_pkg::ST_ROW_WAIT: begin
        if (!cor_busy) begin
          state_nxt = apdb_pkg::ST_SCALE;
        end
      end
      apdb_pkg::ST_SCALE:  state_nxt = scale_ok ? apdb_pkg::ST_RD : apdb_pkg::ST_IDLE;
      apdb_pkg::ST_RD:     state_nxt = apdb_pkg::ST_UPDATE;
      apdb_pkg::ST_UPDATE: state_nxt = apdb_pkg::ST_IDLE;
      default:             state_nxt = apdb_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory port and result word
  always_comb begin
    mode_nxt     = mode_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    h2_nxt       = h2_r;
    d2_nxt       = d2_r;
    col_deg_nxt  = col_deg_r;
    addr_nxt     = addr_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_item_nxt = clr_item_r;
    bin_nxt      = bin_r;
    qrow_nxt     = qrow_r;
    qcol_nxt     = qcol_r;
    we           = 1'b0;
    wa           = clr_cnt_r;
    wd           = apdb_pkg::EMPTY_BIN;
    emit         = 1'b0;
    e_inb        = 1'b0;
    e_row        = '0;
    e_col        = '0;
    e_pix        = apdb_pkg::EMPTY_BIN;
    e_chg        = 1'b0;
    case (state_r)
      apdb_pkg::ST_CLEAR: begin
        // sweep one entry a cycle; report only when a clear word asked for it
        we = 1'b1;
        if (last_clr) begin
          clr_cnt_nxt  = '0;
          clr_item_nxt = 1'b0;
          emit         = clr_item_r;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      apdb_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt = apdb_pkg::mode_t'(in_mode);
          x_nxt    = in_px;
          y_nxt    = in_py;
          z_nxt    = in_pz;
          case (apdb_pkg::mode_t'(in_mode))
            apdb_pkg::MODE_PLOT: begin
            end
            apdb_pkg::MODE_READ: begin
              if (rd_ok) begin
                addr_nxt = ADDR_W'(32'(in_read_row) * SCREEN_COLS + 32'(in_read_col));
                qrow_nxt = MW'(in_read_row);
                qcol_nxt = MW'(in_read_col);
              end else begin
                emit = 1'b1;
              end
            end
            apdb_pkg::MODE_CLEAR: begin
              clr_cnt_nxt  = '0;
              clr_item_nxt = 1'b1;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      apdb_pkg::ST_SQ_X: h2_nxt = H2W'(sq);
      apdb_pkg::ST_SQ_Z: h2_nxt = h2_r + H2W'(sq);
      apdb_pkg::ST_SQ_Y: d2_nxt = h2_r + H2W'(sq);
      apdb_pkg::ST_COL_WAIT: begin
        if (!cor_busy && !sq_busy) begin
          col_deg_nxt = cor_deg;
        end
      end
      apdb_pkg::ST_SCALE: begin
        if (scale_ok) begin
          addr_nxt = ADDR_W'(32'(r_q) * SCREEN_COLS + 32'(c_q));
          qrow_nxt = r_q;
          qcol_nxt = c_q;
          bin_nxt  = bin_calc;
        end else begin
          emit = 1'b1;
        end
      end
      apdb_pkg::ST_UPDATE: begin
        emit  = 1'b1;
        e_inb = 1'b1;
        e_row = qrow_r[5:0];
        e_col = qcol_r[6:0];
        e_pix = rd_q;
        if (mode_r == apdb_pkg::MODE_PLOT) begin
          // keep the nearer bin
          if (lower) begin
            we    = 1'b1;
            wa    = addr_r;
            wd    = bin_r;
            e_pix = bin_r;
            e_chg = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= apdb_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      clr_item_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_item_r   <= clr_item_nxt;
      out_valid_r  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    h2_r      <= h2_nxt;
    d2_r      <= d2_nxt;
    col_deg_r <= col_deg_nxt;
    addr_r    <= addr_nxt;
    bin_r     <= bin_nxt;
    qrow_r    <= qrow_nxt;
    qcol_r    <= qcol_nxt;
    if (emit) begin
      out_in_bounds_r   <= e_inb;
      out_row_r         <= e_row;
      out_col_r         <= e_col;
      out_pixel_value_r <= e_pix;
      out_changed_r     <= e_chg;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_in_bounds   = out_in_bounds_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_pixel_value = out_pixel_value_r;
  assign out_changed     = out_changed_r;

endmodule

@@ hdl/apdb_checker.sv @@
// Port-level checks for the angular point projector, bound onto the top level.
// Depends only on the top level's port names.
module apdb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic       out_in_bounds,
  input logic [5:0] out_row,
  input logic [6:0] out_col,
  input logic [3:0] out_pixel_value,
  input logic       out_changed
);

  // reset starts the clearing sweep, so the block is busy right after
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_pix_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pixel_value >= 4'd1 && out_pixel_value <= 4'd7) ||
                   out_pixel_value == 4'd9))
    else $error("pixel value outside bin codes");

  a_oob_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_bounds) |->
      (out_row == 6'd0 && out_col == 7'd0 && out_pixel_value == 4'd9 && !out_changed))
    else $error("out-of-bounds word not cleared");

  a_changed_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_changed) |-> (out_in_bounds && out_pixel_value <= 4'd7))
    else $error("changed word without a stored bin");

endmodule

bind angular_point_projector_depth_bins apdb_checker u_apdb_checker (.*);

@@ tb/sv/angular_point_projector_depth_bins_tb.sv @@
// Self-checking bench for the angular point projector with depth bins.
// Depends on hdl/apdb_pkg.sv and the top level; a built-in predictor checks every word.
module angular_point_projector_depth_bins_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 90;
  localparam int ROWS = 45;
  localparam int HC = 1;
  localparam int VC = 2;
  localparam int CB = 12;
  localparam int FB = 16;
  localparam int N_RANDOM = 1850;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic       inb;
    logic [5:0] row;
    logic [6:0] col;
    logic [3:0] pix;
    logic       chg;
  } pixel_word_t;

  typedef struct {
    apdb_pkg::mode_t  mode;
    logic [CB-1:0]    x, y, z;
    logic [5:0]       rr;
    logic [6:0]       rc;
    bit               fixed;  // expected word typed in
    pixel_word_t      want;
  } stim_row_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_mode;
  logic signed [CB-1:0] in_px, in_py, in_pz;
  logic [5:0] in_read_row;
  logic [6:0] in_read_col;
  logic out_valid, out_in_bounds, out_changed;
  logic [5:0] out_row;
  logic [6:0] out_col;
  logic [3:0] out_pixel_value;

  angular_point_projector_depth_bins dut (.*);

  // Predictor state: mirror of the screen
  logic [3:0] screen_mirror [ROWS*COLS];
  pixel_word_t pending_words [$];
  int errors = 0;
  int accepted = 0;
  int plots_on_screen = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Fixed-point vectoring pass; returns whole degrees truncated toward zero.
  function automatic longint cordic_degrees(longint a, longint b);
    longint acc, na, nb, da, db, t;
    acc = 0;
    if (a < 0 || (a == 0 && b != 0)) begin
      if (b >= 0) begin
        na = b; nb = -a; acc = longint'(90) <<< FB;
      end else begin
        na = -b; nb = a; acc = -(longint'(90) <<< FB);
      end
      a = na; b = nb;
    end
    for (int i = 0; i < FB; i++) begin
      da = shr_floor(b, i);
      db = shr_floor(a, i);
      t = longint'(atan_q24_round(i));
      if (b > 0) begin
        a += da; b -= db; acc += t;
      end else if (b < 0) begin
        a -= da; b += db; acc -= t;
      end
    end
    if (acc >= 0) return acc >>> FB;
    return -((-acc) >>> FB);
  endfunction

  function automatic longint atan_q24_round(int i);
    longint t;
    int sh;
    t = longint'(apdb_pkg::ATAN_Q24[i]);
    sh = apdb_pkg::TAB_FRAC - FB;
    if (sh == 0) return t;
    return (t + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Compute the word for one accepted command and update the mirror.
  function automatic pixel_word_t project_point(apdb_pkg::mode_t m, logic [CB-1:0] rx,
                                                logic [CB-1:0] ry, logic [CB-1:0] rz,
                                                logic [5:0] rr, logic [6:0] rc);
    pixel_word_t w;
    longint x, y, z, ci, rj, h, d2;
    int idx, bin;
    w = '{inb: 0, row: 0, col: 0, pix: apdb_pkg::EMPTY_BIN, chg: 0};
    case (m)
      apdb_pkg::MODE_PLOT: begin
        x = longint'($signed(rx));
        y = longint'($signed(ry));
        z = longint'($signed(rz));
        ci = cordic_degrees(x * 65536, z * 65536);
        h = int_sqrt(longint'(x * x + z * z) << (2 * apdb_pkg::VEC_FRAC));
        rj = cordic_degrees(h, y * 65536);
        ci = ci / HC;
        rj = rj / VC;
        if (ci >= 0 && rj >= 0 && ci < COLS && rj < ROWS) begin
          d2 = x * x + y * y + z * z;
          bin = 7;
          for (int k = 6; k >= 1; k--) begin
            if (d2 < 3 * (14 * k) * (14 * k)) bin = k;
          end
          idx = int'(rj) * COLS + int'(ci);
          if (screen_mirror[idx] > bin) begin
            screen_mirror[idx] = 4'(bin);
            w.chg = 1;
          end
          w.inb = 1;
          w.row = 6'(rj);
          w.col = 7'(ci);
          w.pix = screen_mirror[idx];
        end
      end
      apdb_pkg::MODE_READ: begin
        if (rr < ROWS && rc < COLS) begin
          w.inb = 1;
          w.row = rr;
          w.col = rc;
          w.pix = screen_mirror[rr * COLS + rc];
        end
      end
      apdb_pkg::MODE_CLEAR: begin
        foreach (screen_mirror[i]) screen_mirror[i] = apdb_pkg::EMPTY_BIN;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Random idle gap: mostly short, sometimes long, often none.
  function automatic int gap_len();
    int n, r;
    r = $urandom_range(0, 99);
    if (r < 40) n = 0;
    else if (r < 92) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 80);
    return n;
  endfunction

  // Hand one command word to the block and queue its expected result.
  // Keep start high when the next word follows at once; drop it before a gap or a pause.
  task automatic send_word(stim_row_t s, bit settle);
    pixel_word_t w;
    int n;
    in_mode <= s.mode;
    in_px <= s.x;
    in_py <= s.y;
    in_pz <= s.z;
    in_read_row <= s.rr;
    in_read_col <= s.rc;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge.
    w = project_point(s.mode, s.x, s.y, s.z, s.rr, s.rc);
    if (s.fixed && w != s.want) begin
      $display("%0t table row disagrees with predictor: expected %p, predicted %p",
               $time, s.want, w);
      errors++;
    end
    pending_words.push_back(w);
    accepted++;
    if (s.mode == apdb_pkg::MODE_PLOT && w.inb) plots_on_screen++;
    n = gap_len();
    if (n != 0 || settle) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      pixel_word_t got, want;
      got = '{inb: out_in_bounds, row: out_row, col: out_col, pix: out_pixel_value,
              chg: out_changed};
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: actual %p", $time, got);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing is accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  function automatic stim_row_t mk(apdb_pkg::mode_t m, int x, int y, int z, int rr, int rc);
    stim_row_t s;
    s.mode = m;
    s.x = CB'(x);
    s.y = CB'(y);
    s.z = CB'(z);
    s.rr = 6'(rr);
    s.rc = 7'(rc);
    s.fixed = 0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t mk_fixed(apdb_pkg::mode_t m, int x, int y, int z, int rr,
                                         int rc, pixel_word_t w);
    stim_row_t s;
    s = mk(m, x, y, z, rr, rc);
    s.fixed = 1;
    s.want = w;
    return s;
  endfunction

  // Random word: a read, clear or no-op, or a point near the viewer, on-screen octant, or full range.
  function automatic stim_row_t random_word();
    int r, lim;
    r = $urandom_range(0, 99);
    if (r < 8) return mk(apdb_pkg::MODE_READ, 0, 0, 0, $urandom_range(0, 63),
                         $urandom_range(0, 127));
    if (r < 10) return mk(apdb_pkg::MODE_READ, 0, 0, 0, $urandom_range(0, 44),
                          $urandom_range(0, 89));
    if (r == 10) return mk(apdb_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
    if (r == 11) return mk(apdb_pkg::MODE_NOP, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
    if (r < 70) begin
      // Mostly x,z,y >= 0 so the point lands on screen; sizes cover every depth bin.
      lim = ($urandom_range(0, 3) == 0) ? 2047 : 160;
      return mk(apdb_pkg::MODE_PLOT, $urandom_range(0, lim), $urandom_range(0, lim),
                $urandom_range(0, lim), $urandom, $urandom);
    end
    return mk(apdb_pkg::MODE_PLOT, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  stim_row_t directed [$];
  pixel_word_t blank_word;

  initial begin
    rst_n = 0;
    start = 0;
    in_mode = apdb_pkg::MODE_NOP;
    in_px = '0;
    in_py = '0;
    in_pz = '0;
    in_read_row = '0;
    in_read_col = '0;
    foreach (screen_mirror[i]) screen_mirror[i] = apdb_pkg::EMPTY_BIN;
    blank_word = '{inb: 0, row: 0, col: 0, pix: apdb_pkg::EMPTY_BIN, chg: 0};

    // Directed table: reset contents, extremes, each mode and each special case.
    directed.push_back(mk_fixed(apdb_pkg::MODE_READ, 0, 0, 0, 0, 0,
                                '{inb: 1, row: 0, col: 0, pix: apdb_pkg::EMPTY_BIN, chg: 0}));
    directed.push_back(mk_fixed(apdb_pkg::MODE_READ, 0, 0, 0, 44, 89,
                                '{inb: 1, row: 44, col: 89, pix: apdb_pkg::EMPTY_BIN,
                                  chg: 0}));
    directed.push_back(mk_fixed(apdb_pkg::MODE_READ, 0, 0, 0, 45, 0, blank_word));
    directed.push_back(mk_fixed(apdb_pkg::MODE_READ, 0, 0, 0, 0, 90, blank_word));
    directed.push_back(mk_fixed(apdb_pkg::MODE_READ, 0, 0, 0, 63, 127, blank_word));
    // Origin lands on row 0, column 0 with the nearest bin.
    directed.push_back(mk_fixed(apdb_pkg::MODE_PLOT, 0, 0, 0, 0, 0,
                                '{inb: 1, row: 0, col: 0, pix: 1, chg: 1}));
    directed.push_back(mk_fixed(apdb_pkg::MODE_PLOT, 0, 0, 0, 0, 0,
                                '{inb: 1, row: 0, col: 0, pix: 1, chg: 0}));
    // Negative x or negative z points land off screen.
    directed.push_back(mk_fixed(apdb_pkg::MODE_PLOT, -2048, 0, 0, 0, 0, blank_word));
    directed.push_back(mk_fixed(apdb_pkg::MODE_PLOT, 0, 0, -2048, 0, 0, blank_word));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 2047, 2047, 2047, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 2047, 0, 0, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 0, 0, 2047, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 0, 2047, 0, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 0, -2048, 0, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, -2048, -2048, -2048, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 10, 3, 10, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 40, 12, 40, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 13, 4, 13, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 100, 30, 100, 0, 0));
    directed.push_back(mk(apdb_pkg::MODE_PLOT, 1, 1, 1, 0, 0));
    directed.push_back(mk_fixed(apdb_pkg::MODE_NOP, 2047, 2047, 2047, 63, 127, blank_word));
    directed.push_back(mk_fixed(apdb_pkg::MODE_CLEAR, -1, -1, -1, 63, 127, blank_word));
    directed.push_back(mk_fixed(apdb_pkg::MODE_READ, 0, 0, 0, 0, 0,
                                '{inb: 1, row: 0, col: 0, pix: apdb_pkg::EMPTY_BIN, chg: 0}));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_word(directed[i], 1'b0);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Hold off once until every expected word has arrived.
      if (n == N_RANDOM / 2) begin
        while (pending_words.size() != 0 && !timed_out) @(posedge clk);
      end
      if (timed_out) break;
      send_word(random_word(), (n == N_RANDOM / 2 - 1) || (n == N_RANDOM - 1));
    end

    while (pending_words.size() != 0 && !timed_out) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!timed_out) begin
      $display("Covered %0d commands (%0d plots on screen) over plot, read, clear and no-op.",
               accepted, plots_on_screen);
      if (errors == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
      $finish;
    end
  end

  // The watchdog limit covers the reset sweep of the screen.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("%0t watchdog expired with %0d words outstanding", $time,
               pending_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
